// ----- design/rrr_pkg.sv -----
package rrr_pkg;

  // Fixed field widths
  localparam int unsigned ID_W  = 4;
  localparam int unsigned CMD_W = 2;

  // Default ring size
  localparam int unsigned THREAD_COUNT_DEF = 16;

  // Idle sentinel thread
  localparam logic [ID_W-1:0] IDLE_ID = '0;

  // Command codes (code 3 is unused and answers a failure)
  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT  = 2'd0,
    CMD_REMOVE  = 2'd1,
    CMD_ADVANCE = 2'd2
  } rrr_cmd_e;

  // Datapath link operations, one per cycle
  typedef enum logic [2:0] {
    OP_NONE       = 3'd0,
    OP_INS_FIRST  = 3'd1,
    OP_INS_TAIL   = 3'd2,
    OP_INS_HEAD   = 3'd3,
    OP_REM_LONE   = 3'd4,
    OP_REM_UNLINK = 3'd5,
    OP_REM_CLEAR  = 3'd6,
    OP_ADV        = 3'd7
  } rrr_op_e;

  // Controller to datapath
  typedef struct packed {
    logic    capture;
    rrr_op_e op;
    logic    status_we;
    logic    status_val;
    logic    load_out;
  } rrr_ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             id_bad;
    logic             is_ready;
    logic             ring_empty;
    logic             lone;
    logic             out_free;
  } rrr_sts_t;

endpackage

// ----- design/rrr_ctrl.sv -----
module rrr_ctrl
  import rrr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  rrr_sts_t sts_i,
  output rrr_ctl_t ctl_o
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_LOOK  = 5'b00010,
    ST_LINK2 = 5'b00100,
    ST_CLEAR = 5'b01000,
    ST_RESP  = 5'b10000
  } rrr_state_e;

  rrr_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

  // Sequencing of one transaction
  always_comb begin
    state_d        = state_q;
    ctl_o          = '0;
    ctl_o.op       = OP_NONE;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ctl_o.capture = 1'b1;
          state_d       = ST_LOOK;
        end
      end
      ST_LOOK: begin
        ctl_o.status_we = 1'b1;
        state_d         = ST_RESP;
        case (sts_i.cmd)
          CMD_INSERT: begin
            if (sts_i.id_bad || sts_i.is_ready) begin
              ctl_o.status_val = 1'b1;
            end else if (sts_i.ring_empty) begin
              ctl_o.op = OP_INS_FIRST;
            end else begin
              ctl_o.op = OP_INS_TAIL;
              state_d  = ST_LINK2;
            end
          end
          CMD_REMOVE: begin
            if (sts_i.id_bad || !sts_i.is_ready) begin
              ctl_o.status_val = 1'b1;
            end else if (sts_i.lone) begin
              ctl_o.op = OP_REM_LONE;
            end else begin
              ctl_o.op = OP_REM_UNLINK;
              state_d  = ST_CLEAR;
            end
          end
          CMD_ADVANCE: begin
            ctl_o.op = OP_ADV;
          end
          default: begin
            ctl_o.status_val = 1'b1;
          end
        endcase
      end
      ST_LINK2: begin
        ctl_o.op = OP_INS_HEAD;
        state_d  = ST_RESP;
      end
      ST_CLEAR: begin
        ctl_o.op = OP_REM_CLEAR;
        state_d  = ST_RESP;
      end
      ST_RESP: begin
        if (sts_i.out_free) begin
          ctl_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- design/rrr_dpath.sv -----
module rrr_dpath
  import rrr_pkg::*;
#(
  parameter int unsigned THREAD_COUNT = THREAD_COUNT_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [CMD_W-1:0] cmd_i,
  input  logic [ID_W-1:0]  thread_id_i,
  input  rrr_ctl_t         ctl_i,
  output rrr_sts_t         sts_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             status_o,
  output logic [ID_W-1:0]  run_tid_o,
  output logic [ID_W-1:0]  pend_tid_o
);

  // Only ids that fit the id field can ever be linked
  localparam int unsigned MaxIds = 1 << ID_W;
  localparam int unsigned Depth  = (THREAD_COUNT < MaxIds) ? THREAD_COUNT : MaxIds;
  localparam int unsigned IdxW   = $clog2(Depth);

  typedef logic [IdxW-1:0] idx_t;

  // Link memories and their valid bits
  idx_t             next_mem [Depth];
  idx_t             prev_mem [Depth];
  logic [Depth-1:0] next_vld_q;
  logic [Depth-1:0] prev_vld_q;

  // Captured transaction and read data
  logic [CMD_W-1:0] cmd_q;
  logic [ID_W-1:0]  tid_q;
  idx_t             rd_next_q, rd_prev_q;

  // Ring ends and thread pointers
  idx_t head_q, tail_q, running_q, upcoming_q;
  logic status_q;

  // Output register
  logic            out_valid_q;
  logic            out_status_q;
  logic [ID_W-1:0] out_cur_q, out_pend_q;

  idx_t tid_idx, rd_addr;
  logic n_we, p_we;
  idx_t n_wa, n_wd, p_wa, p_wd;

  assign tid_idx = tid_q[IdxW-1:0];
  assign rd_addr = (cmd_i == CMD_ADVANCE) ? upcoming_q : thread_id_i[IdxW-1:0];

  // Write port selection per link operation
  always_comb begin
    n_we = 1'b0;
    p_we = 1'b0;
    n_wa = tid_idx;
    n_wd = '0;
    p_wa = tid_idx;
    p_wd = '0;
    case (ctl_i.op)
      OP_INS_FIRST: begin
        n_we = 1'b1;
        n_wd = tid_idx;
        p_we = 1'b1;
        p_wd = tid_idx;
      end
      OP_INS_TAIL: begin
        n_we = 1'b1;
        n_wa = tail_q;
        n_wd = tid_idx;
        p_we = 1'b1;
        p_wd = tail_q;
      end
      OP_INS_HEAD: begin
        n_we = 1'b1;
        n_wd = head_q;
        p_we = 1'b1;
        p_wa = head_q;
        p_wd = tid_idx;
      end
      OP_REM_LONE, OP_REM_CLEAR: begin
        n_we = 1'b1;
        p_we = 1'b1;
      end
      OP_REM_UNLINK: begin
        n_we = 1'b1;
        n_wa = rd_prev_q;
        n_wd = rd_next_q;
        p_we = 1'b1;
        p_wa = rd_next_q;
        p_wd = rd_prev_q;
      end
      default: begin
      end
    endcase
  end

  // Link memory arrays
  always_ff @(posedge clk_i) begin
    if (n_we) begin
      next_mem[n_wa] <= n_wd;
    end
    if (p_we) begin
      prev_mem[p_wa] <= p_wd;
    end
  end

  // Entries never written read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_vld_q <= '0;
      prev_vld_q <= '0;
    end else begin
      if (n_we) begin
        next_vld_q[n_wa] <= 1'b1;
      end
      if (p_we) begin
        prev_vld_q[p_wa] <= 1'b1;
      end
    end
  end

  // Registered reads and command capture
  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      cmd_q     <= cmd_i;
      tid_q     <= thread_id_i;
      rd_next_q <= next_vld_q[rd_addr] ? next_mem[rd_addr] : '0;
      rd_prev_q <= prev_vld_q[rd_addr] ? prev_mem[rd_addr] : '0;
    end
  end

  // Ring ends, thread pointers and status
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= '0;
      tail_q     <= '0;
      running_q  <= '0;
      upcoming_q <= '0;
      status_q   <= 1'b0;
    end else begin
      if (ctl_i.status_we) begin
        status_q <= ctl_i.status_val;
      end
      case (ctl_i.op)
        OP_INS_FIRST: begin
          head_q <= tid_idx;
          tail_q <= tid_idx;
        end
        OP_INS_HEAD: begin
          tail_q <= tid_idx;
        end
        OP_REM_LONE: begin
          head_q <= '0;
          tail_q <= '0;
        end
        OP_REM_UNLINK: begin
          if (head_q == tid_idx) begin
            head_q <= rd_next_q;
          end
          if (tail_q == tid_idx) begin
            tail_q <= rd_prev_q;
          end
        end
        OP_ADV: begin
          running_q  <= upcoming_q;
          upcoming_q <= (upcoming_q == '0) ? head_q : rd_next_q;
        end
        default: begin
        end
      endcase
    end
  end

  // Output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (ctl_i.load_out) begin
      out_status_q <= status_q;
      out_cur_q    <= ID_W'(running_q);
      out_pend_q   <= ID_W'(upcoming_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign run_tid_o   = out_cur_q;
  assign pend_tid_o  = out_pend_q;

  // Status toward the controller
  assign sts_o.cmd        = cmd_q;
  assign sts_o.id_bad     = (tid_q == IDLE_ID) || (32'(tid_q) >= THREAD_COUNT);
  assign sts_o.is_ready   = (rd_next_q != '0);
  assign sts_o.ring_empty = (head_q == '0);
  assign sts_o.lone       = (head_q == tid_idx) && (tail_q == tid_idx);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

endmodule

// ----- design/round_robin_ready_ring.sv -----
// Channel | Handshake               | Payload
// --------+-------------------------+---------------------------------------------
// in      | in_valid_i / in_ready_o | cmd_i, thread_id_i
// out     | out_valid_o/out_ready_i | status_o, run_tid_o, pend_tid_o
//
// One transaction at a time: advance, failures, an insert into an empty ring and
// a remove of a lone thread pass through the look and response states; other
// inserts and removes pass through LINK2 or CLEAR between them. The response
// state waits while an earlier result is still unaccepted in the output register.
// The extra state is due to the one write port on each of the next and prev link
// memories. Reset clears the ring to empty and both threads to idle at once.
// A finished result waits in the output register while the next input is taken.
module round_robin_ready_ring
  import rrr_pkg::*;
#(
  parameter int unsigned THREAD_COUNT = THREAD_COUNT_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [CMD_W-1:0] cmd_i,
  input  logic [ID_W-1:0]  thread_id_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             status_o,
  output logic [ID_W-1:0]  run_tid_o,
  output logic [ID_W-1:0]  pend_tid_o
);

  rrr_ctl_t ctl;
  rrr_sts_t sts;

  // Sequencer
  rrr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  // Link memories, pointers and result register
  rrr_dpath #(
    .THREAD_COUNT (THREAD_COUNT)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_i),
    .thread_id_i (thread_id_i),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .run_tid_o   (run_tid_o),
    .pend_tid_o  (pend_tid_o)
  );

endmodule

// ----- design/rrr_check.sv -----
module rrr_check
  import rrr_pkg::*;
#(
  parameter int unsigned THREAD_COUNT = THREAD_COUNT_DEF
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_o,
  input logic [CMD_W-1:0] cmd_i,
  input logic [ID_W-1:0]  thread_id_i,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic             status_o,
  input logic [ID_W-1:0]  run_tid_o,
  input logic [ID_W-1:0]  pend_tid_o
);

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(run_tid_o) && $stable(pend_tid_o))
    else $error("stalled result changed");

  // Only one transaction in work at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while busy");

  // Threads shown are always inside the ring's range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(run_tid_o) < THREAD_COUNT)
      && (32'(pend_tid_o) < THREAD_COUNT))
    else $error("thread out of range");

  // A result does not rise too soon after a transaction is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> ##1 !out_valid_o || !$rose(out_valid_o))
    else $error("result appeared too early");

endmodule

bind round_robin_ready_ring rrr_check #(.THREAD_COUNT(THREAD_COUNT)) u_rrr_check (.*);

// ----- tb/round_robin_ready_ring_tb.sv -----
`timescale 1ns / 100ps

module round_robin_ready_ring_tb;
  import rrr_pkg::*;

  // Code 3 has no enum member; the block answers it as a failure
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned N_RANDOM = 900;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned LONG_HOLD = 200;
  localparam int unsigned HOLD_AT = 400;

  typedef struct {
    logic [CMD_W-1:0] cmd;
    logic [ID_W-1:0]  tid;
    bit               drain;
  } ring_cmd_t;

  typedef struct {
    logic            status;
    logic [ID_W-1:0] cur;
    logic [ID_W-1:0] pend;
  } ring_resp_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready_o;
  logic [CMD_W-1:0] cmd = CMD_INSERT;
  logic [ID_W-1:0]  tid = '0;
  logic             out_valid_o;
  logic             out_ready = 1'b0;
  logic             status_o;
  logic [ID_W-1:0]  run_tid_o;
  logic [ID_W-1:0]  pend_tid_o;

  // Shadow copy of the ring
  logic [ID_W-1:0] fwd_link [THREAD_COUNT_DEF] = '{default: '0};
  logic [ID_W-1:0] bwd_link [THREAD_COUNT_DEF] = '{default: '0};
  logic [ID_W-1:0] running_tid = IDLE_ID;
  logic [ID_W-1:0] upcoming_tid = IDLE_ID;

  ring_cmd_t  cmd_q [$];
  ring_resp_t resp_q [$];
  ring_cmd_t  next_cmd;
  ring_resp_t want;

  int unsigned n_cmds = 0;
  int unsigned n_taken = 0;
  int unsigned n_results = 0;
  int unsigned errors = 0;
  int unsigned gap_left = 0;
  int unsigned calm_in = 0;
  int unsigned stall_left = 0;
  int unsigned calm_out = 0;
  int unsigned hold_left = 0;
  int unsigned idle_cycles = 0;

  round_robin_ready_ring dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd),
    .thread_id_i (tid),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .status_o    (status_o),
    .run_tid_o   (run_tid_o),
    .pend_tid_o  (pend_tid_o)
  );

  always #1 clk_i = ~clk_i;

  // Apply one command to the shadow ring and return the expected answer
  function automatic ring_resp_t predict_ring(logic [CMD_W-1:0] c, logic [ID_W-1:0] t);
    ring_resp_t      r;
    logic [ID_W-1:0] head;
    logic [ID_W-1:0] tail;
    logic [ID_W-1:0] p;
    logic [ID_W-1:0] n;
    r.status = 1'b1;
    head = fwd_link[IDLE_ID];
    tail = bwd_link[IDLE_ID];
    case (c)
      CMD_INSERT: begin
        if (t != IDLE_ID && fwd_link[t] == IDLE_ID) begin
          if (head == IDLE_ID) begin
            // first thread links to itself
            fwd_link[IDLE_ID] = t;
            bwd_link[IDLE_ID] = t;
            fwd_link[t] = t;
            bwd_link[t] = t;
          end else begin
            fwd_link[tail] = t;
            bwd_link[t] = tail;
            fwd_link[t] = head;
            bwd_link[head] = t;
            bwd_link[IDLE_ID] = t;
          end
          r.status = 1'b0;
        end
      end
      CMD_REMOVE: begin
        if (t != IDLE_ID && fwd_link[t] != IDLE_ID) begin
          if (head == t && tail == t) begin
            fwd_link[IDLE_ID] = IDLE_ID;
            bwd_link[IDLE_ID] = IDLE_ID;
          end else begin
            p = bwd_link[t];
            n = fwd_link[t];
            fwd_link[p] = n;
            bwd_link[n] = p;
            if (head == t) fwd_link[IDLE_ID] = n;
            if (tail == t) bwd_link[IDLE_ID] = p;
          end
          fwd_link[t] = IDLE_ID;
          bwd_link[t] = IDLE_ID;
          r.status = 1'b0;
        end
      end
      CMD_ADVANCE: begin
        running_tid = upcoming_tid;
        upcoming_tid = fwd_link[running_tid];
        r.status = 1'b0;
      end
      default: ;
    endcase
    r.cur = running_tid;
    r.pend = upcoming_tid;
    return r;
  endfunction

  task automatic add_cmd(logic [CMD_W-1:0] c, logic [ID_W-1:0] t, bit drain = 1'b0);
    ring_cmd_t item;
    item.cmd = c;
    item.tid = t;
    item.drain = drain;
    cmd_q.push_back(item);
    n_cmds++;
  endtask

  // Driver: predict on acceptance, then present the next command after its gap
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      cmd      <= CMD_INSERT;
      tid      <= '0;
    end else begin
      if (in_valid && in_ready_o) begin
        resp_q.push_back(predict_ring(cmd, tid));
        n_taken++;
        if (calm_in > 0) begin
          calm_in--;
          gap_left = 0;
        end else begin
          gap_left = $urandom_range(0, 3);
          if ($urandom_range(0, 15) == 0) calm_in = 24;
        end
      end
      if (!in_valid || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (cmd_q.size() != 0 && !(cmd_q[0].drain && resp_q.size() != 0)) begin
          next_cmd = cmd_q.pop_front();
          in_valid <= 1'b1;
          cmd      <= next_cmd.cmd;
          tid      <= next_cmd.tid;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transaction, then pace out_ready
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        if (resp_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got status %0b current %0d pending %0d",
                   $time, status_o, run_tid_o, pend_tid_o);
          errors++;
        end else begin
          want = resp_q.pop_front();
          if (status_o !== want.status) begin
            $display("%0t: status mismatch, expected %0b got %0b", $time, want.status, status_o);
            errors++;
          end
          if (run_tid_o !== want.cur) begin
            $display("%0t: running thread mismatch, expected %0d got %0d",
                     $time, want.cur, run_tid_o);
            errors++;
          end
          if (pend_tid_o !== want.pend) begin
            $display("%0t: upcoming thread mismatch, expected %0d got %0d",
                     $time, want.pend, pend_tid_o);
            errors++;
          end
        end
        n_results++;
        // long back-pressure once, so the block fills and stalls its input
        if (n_results == HOLD_AT) hold_left = LONG_HOLD;
        if (calm_out > 0) begin
          calm_out--;
          stall_left = 0;
        end else begin
          stall_left = $urandom_range(0, 3);
          if ($urandom_range(0, 15) == 0) calm_out = 24;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: cycles with no transaction on either channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: timeout, %0d of %0d commands taken, %0d results outstanding",
                 $time, n_taken, n_cmds, resp_q.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    int unsigned sel;
    logic [ID_W-1:0] rid;

    // Directed: bad ids, duplicates, pending removal, head/tail/middle/lone removal
    add_cmd(CMD_ADVANCE, 4'd9);
    add_cmd(CMD_INSERT, IDLE_ID);
    add_cmd(CMD_REMOVE, IDLE_ID);
    add_cmd(CMD_REMOVE, 4'd5);
    add_cmd(CMD_INSERT, 4'd15);
    add_cmd(CMD_INSERT, 4'd15);
    add_cmd(CMD_INSERT, 4'd1);
    add_cmd(CMD_INSERT, 4'd2);
    add_cmd(CMD_INSERT, 4'd4);
    add_cmd(CMD_INSERT, 4'd8);
    add_cmd(CMD_ADVANCE, 4'd0);
    add_cmd(CMD_ADVANCE, 4'd15);
    add_cmd(CMD_REMOVE, 4'd1);
    add_cmd(CMD_ADVANCE, 4'd0);
    add_cmd(CMD_ADVANCE, 4'd0);
    add_cmd(CMD_UNUSED, 4'd10);
    add_cmd(CMD_REMOVE, 4'd15);
    add_cmd(CMD_REMOVE, 4'd8);
    add_cmd(CMD_INSERT, 4'd10);
    add_cmd(CMD_REMOVE, 4'd4);
    add_cmd(CMD_ADVANCE, 4'd0);
    add_cmd(CMD_REMOVE, 4'd2);
    add_cmd(CMD_REMOVE, 4'd10);
    add_cmd(CMD_INSERT, 4'd7);
    add_cmd(CMD_REMOVE, 4'd7);
    add_cmd(CMD_ADVANCE, 4'd0);

    // Random: mostly valid ids, some idle id and unused code
    for (int unsigned i = 0; i < N_RANDOM; i++) begin
      sel = $urandom_range(0, 19);
      rid = ($urandom_range(0, 9) == 0) ? IDLE_ID : 4'($urandom_range(1, 15));
      if (sel < 7) add_cmd(CMD_INSERT, rid, (i % 200) == 0);
      else if (sel < 13) add_cmd(CMD_REMOVE, rid, (i % 200) == 0);
      else if (sel < 19) add_cmd(CMD_ADVANCE, 4'($urandom_range(0, 15)), (i % 200) == 0);
      else add_cmd(CMD_UNUSED, rid, (i % 200) == 0);
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (n_taken != n_cmds) @(posedge clk_i);
    while (resp_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
